[rtl/core/etrl_pkg.sv]
// Shared types, codes and constants for the escaped trace ring logger.
// Depends on nothing; every other file of the logger refers to it by scoped name.
package etrl_pkg;

    localparam int LOG_DEPTH_DEF  = 4096;
    localparam int NUM_LOGS_DEF   = 4;
    localparam int TIME_BYTES_DEF = 8;

    localparam int CMD_W      = 2;
    localparam int SEL_W      = 2;
    localparam int BYTE_W     = 8;
    localparam int TS_W       = 64;
    localparam int OFF_W      = 12;
    localparam int FILL_OUT_W = 13;

    // Power of two, so the queue pointers wrap on their own.
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CMD_W-1:0] CMD_STORE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    localparam logic [BYTE_W-1:0] ESCAPE_MARK = 8'hAA;

    typedef enum logic [2:0] {
        OP_STORE,
        OP_CLEAR,
        OP_READ,
        OP_NOP,
        OP_BADLOG
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [SEL_W-1:0]   log_select;
        logic [BYTE_W-1:0]  frame_type;
        logic [BYTE_W-1:0]  data_byte;
        logic [TS_W-1:0]    timestamp;
        logic [OFF_W-1:0]   read_offset;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_slot;

endpackage

[rtl/core/etrl_front.sv]
// Front end of the trace logger: takes input beats and classifies them.
// Depends on etrl_pkg; feeds etrl_queue.
module etrl_front #(
    parameter int NUM_LOGS = etrl_pkg::NUM_LOGS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [etrl_pkg::CMD_W-1:0]     i_cmd,
    input  logic [etrl_pkg::SEL_W-1:0]     i_log_select,
    input  logic [etrl_pkg::BYTE_W-1:0]    i_frame_type,
    input  logic [etrl_pkg::BYTE_W-1:0]    i_data_byte,
    input  logic [etrl_pkg::TS_W-1:0]      i_timestamp,
    input  logic [etrl_pkg::OFF_W-1:0]     i_read_offset,
    input  logic                           i_queue_full,
    output etrl_pkg::t_slot                o_push
);

    logic            r_valid;
    etrl_pkg::t_item r_item;
    etrl_pkg::t_item n_item;
    logic            accept;
    logic            push;

    assign push       = r_valid && !i_queue_full;
    assign o_in_stall = r_valid && i_queue_full;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_item.log_select  = i_log_select;
        n_item.frame_type  = i_frame_type;
        n_item.data_byte   = i_data_byte;
        n_item.timestamp   = i_timestamp;
        n_item.read_offset = i_read_offset;
        if (32'(i_log_select) >= NUM_LOGS) begin
            n_item.op = etrl_pkg::OP_BADLOG;
        end else begin
            case (i_cmd)
                etrl_pkg::CMD_STORE: n_item.op = etrl_pkg::OP_STORE;
                etrl_pkg::CMD_CLEAR: n_item.op = etrl_pkg::OP_CLEAR;
                etrl_pkg::CMD_READ:  n_item.op = etrl_pkg::OP_READ;
                default:             n_item.op = etrl_pkg::OP_NOP;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

    assign o_push.valid = push;
    assign o_push.item  = r_item;

endmodule

[rtl/core/etrl_queue.sv]
// Short queue between the front and back ends of the trace logger.
// Depends on etrl_pkg.
module etrl_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  etrl_pkg::t_slot i_push,
    output logic            o_full,
    output etrl_pkg::t_slot o_head,
    input  logic            i_pop
);

    localparam int QPW = (etrl_pkg::QUEUE_DEPTH > 1) ? $clog2(etrl_pkg::QUEUE_DEPTH) : 1;

    etrl_pkg::t_item r_slot [etrl_pkg::QUEUE_DEPTH];
    logic [QPW-1:0]  r_wr;
    logic [QPW-1:0]  r_rd;
    logic [QPW:0]    r_cnt;
    logic            do_push;
    logic            do_pop;

    assign o_full       = (r_cnt == (QPW+1)'(etrl_pkg::QUEUE_DEPTH));
    assign o_head.valid = (r_cnt != '0);
    assign o_head.item  = r_slot[r_rd];
    assign do_push      = i_push.valid && !o_full;
    assign do_pop       = i_pop && o_head.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr] <= i_push.item;
        end
    end

endmodule

[rtl/core/etrl_back.sv]
// Back end of the trace logger: per-log ring state, byte sequencer, trace memory
// and the result register. Depends on etrl_pkg; fed by etrl_queue.
module etrl_back #(
    parameter int LOG_DEPTH  = etrl_pkg::LOG_DEPTH_DEF,
    parameter int NUM_LOGS   = etrl_pkg::NUM_LOGS_DEF,
    parameter int TIME_BYTES = etrl_pkg::TIME_BYTES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  etrl_pkg::t_slot                   i_head,
    output logic                              o_pop,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [etrl_pkg::BYTE_W-1:0]       o_read_byte,
    output logic                              o_read_valid,
    output logic [etrl_pkg::FILL_OUT_W-1:0]   o_fill_level_out,
    output logic                              o_accepted
);

    localparam int PW        = $clog2(LOG_DEPTH);
    localparam int FW        = $clog2(LOG_DEPTH + 1);
    localparam int LW        = (NUM_LOGS > 1) ? $clog2(NUM_LOGS) : 1;
    localparam int SW        = ((PW > etrl_pkg::OFF_W) ? PW : etrl_pkg::OFF_W) + 1;
    localparam int TCW       = (TIME_BYTES > 1) ? $clog2(TIME_BYTES) : 1;
    localparam int AW        = LW + PW;
    localparam int MEM_DEPTH = 1 << AW;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_PUSH,
        S_RADDR,
        S_RMEM,
        S_RESP
    } t_state;

    typedef enum logic [2:0] {
        PH_MARK,
        PH_TYPE,
        PH_TIME,
        PH_ESC,
        PH_DATA
    } t_phase;

    t_state r_state;
    t_phase r_phase;

    // Per-log ring state
    logic [PW-1:0] r_wp_a    [NUM_LOGS];
    logic [PW-1:0] r_op_a    [NUM_LOGS];
    logic [FW-1:0] r_fill_a  [NUM_LOGS];
    logic [7:0]    r_last_a  [NUM_LOGS];
    logic          r_pend_a  [NUM_LOGS];

    // Working copy of the current item and log
    etrl_pkg::t_item              r_cur;
    logic [LW-1:0]                r_lg;
    logic [PW-1:0]                r_wp;
    logic [PW-1:0]                r_op;
    logic [FW-1:0]                r_fill;
    logic [etrl_pkg::TS_W-1:0]    r_ts;
    logic [TCW-1:0]               r_tcnt;
    logic [SW-1:0]                r_sum;
    logic                         r_rvalid;
    logic [AW-1:0]                r_raddr;
    logic [7:0]                   r_rdata;

    logic                         r_out_valid;
    logic [7:0]                   r_read_byte;
    logic                         r_read_valid;
    logic [etrl_pkg::FILL_OUT_W-1:0] r_fill_out;
    logic                         r_accepted;

    logic [7:0]    r_mem [MEM_DEPTH];

    logic [LW+etrl_pkg::SEL_W-1:0]      lg_ext;
    logic [SW-1:0]                      off_ext;
    logic [SW-1:0]                      old_ext;
    logic [SW-1:0]                      fill_ext;
    logic [SW-1:0]                      pos_w;
    logic [7:0]                         push_byte;
    logic [PW-1:0]                      n_wp;
    logic [PW-1:0]                      n_op;
    logic [FW-1:0]                      n_fill;
    logic                               log_full;
    logic                               out_free;
    logic                               mem_we;
    logic [AW-1:0]                      mem_waddr;
    logic [FW+etrl_pkg::FILL_OUT_W-1:0] fill_wide;
    logic                               clr;
    logic [7:0]                         eff_last;

    assign lg_ext   = {{LW{1'b0}}, i_head.item.log_select};
    assign off_ext  = {{(SW-etrl_pkg::OFF_W){1'b0}}, r_cur.read_offset};
    assign old_ext  = {{(SW-PW){1'b0}}, r_op_a[r_lg]};
    assign fill_ext = SW'(r_fill_a[r_lg]);
    assign pos_w    = (r_sum >= SW'(LOG_DEPTH)) ? (r_sum - SW'(LOG_DEPTH)) : r_sum;
    assign clr      = r_pend_a[r_lg];
    assign eff_last = clr ? 8'd0 : r_last_a[r_lg];

    assign out_free  = !r_out_valid || !i_out_stall;
    assign o_pop     = (r_state == S_IDLE) && i_head.valid;
    assign fill_wide = {{etrl_pkg::FILL_OUT_W{1'b0}}, r_fill};

    // Ring pointer arithmetic for one pushed byte
    assign log_full = (r_fill == FW'(LOG_DEPTH));
    assign n_wp     = (r_wp == PW'(LOG_DEPTH - 1)) ? '0 : r_wp + 1'b1;
    assign n_op     = log_full ? ((r_op == PW'(LOG_DEPTH - 1)) ? '0 : r_op + 1'b1) : r_op;
    assign n_fill   = log_full ? r_fill : r_fill + 1'b1;

    always_comb begin
        case (r_phase)
            PH_MARK: push_byte = etrl_pkg::ESCAPE_MARK;
            PH_TYPE: push_byte = r_cur.frame_type;
            PH_TIME: push_byte = r_ts[7:0];
            PH_ESC:  push_byte = etrl_pkg::ESCAPE_MARK;
            PH_DATA: push_byte = r_cur.data_byte;
            default: push_byte = etrl_pkg::ESCAPE_MARK;
        endcase
    end

    assign mem_we    = (r_state == S_PUSH);
    assign mem_waddr = {r_lg, r_wp};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= push_byte;
        end
        r_rdata <= r_mem[r_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            for (int k = 0; k < NUM_LOGS; k++) begin
                r_wp_a[k]   <= '0;
                r_op_a[k]   <= '0;
                r_fill_a[k] <= '0;
                r_last_a[k] <= '0;
                r_pend_a[k] <= 1'b0;
            end
        end else begin
            if ((r_state == S_RESP) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_head.valid) begin
                        r_cur   <= i_head.item;
                        r_lg    <= lg_ext[LW-1:0];
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    case (r_cur.op)
                        etrl_pkg::OP_STORE: begin
                            // Apply a pending clear before the first byte lands
                            r_wp   <= clr ? '0 : r_wp_a[r_lg];
                            r_op   <= clr ? '0 : r_op_a[r_lg];
                            r_fill <= clr ? '0 : r_fill_a[r_lg];
                            r_pend_a[r_lg] <= 1'b0;
                            r_last_a[r_lg] <= r_cur.frame_type;
                            r_ts   <= r_cur.timestamp;
                            r_tcnt <= TCW'(TIME_BYTES - 1);
                            if (r_cur.frame_type != eff_last) begin
                                r_phase <= PH_MARK;
                            end else if (r_cur.data_byte == etrl_pkg::ESCAPE_MARK) begin
                                r_phase <= PH_ESC;
                            end else begin
                                r_phase <= PH_DATA;
                            end
                            r_state <= S_PUSH;
                        end
                        etrl_pkg::OP_CLEAR: begin
                            r_fill         <= r_fill_a[r_lg];
                            r_pend_a[r_lg] <= 1'b1;
                            r_state        <= S_RESP;
                        end
                        etrl_pkg::OP_READ: begin
                            r_fill   <= r_fill_a[r_lg];
                            r_rvalid <= (off_ext < fill_ext);
                            r_sum    <= old_ext + off_ext;
                            r_state  <= S_RADDR;
                        end
                        default: begin
                            r_fill  <= r_fill_a[r_lg];
                            r_state <= S_RESP;
                        end
                    endcase
                end
                S_PUSH: begin
                    r_wp   <= n_wp;
                    r_op   <= n_op;
                    r_fill <= n_fill;
                    case (r_phase)
                        PH_MARK: r_phase <= PH_TYPE;
                        PH_TYPE: r_phase <= PH_TIME;
                        PH_TIME: begin
                            r_ts <= {8'd0, r_ts[etrl_pkg::TS_W-1:8]};
                            if (r_tcnt == '0) begin
                                r_phase <= (r_cur.data_byte == etrl_pkg::ESCAPE_MARK)
                                           ? PH_ESC : PH_DATA;
                            end else begin
                                r_tcnt <= r_tcnt - 1'b1;
                            end
                        end
                        PH_ESC:  r_phase <= PH_DATA;
                        default: r_state <= S_RESP;
                    endcase
                end
                S_RADDR: begin
                    r_raddr <= {r_lg, pos_w[PW-1:0]};
                    r_state <= S_RMEM;
                end
                S_RMEM: begin
                    r_state <= S_RESP;
                end
                S_RESP: begin
                    if (out_free) begin
                        r_accepted   <= (r_cur.op != etrl_pkg::OP_BADLOG);
                        r_read_valid <= (r_cur.op == etrl_pkg::OP_READ) && r_rvalid;
                        r_read_byte  <= ((r_cur.op == etrl_pkg::OP_READ) && r_rvalid)
                                        ? r_rdata : 8'd0;
                        r_fill_out   <= (r_cur.op == etrl_pkg::OP_BADLOG)
                                        ? '0 : fill_wide[etrl_pkg::FILL_OUT_W-1:0];
                        if (r_cur.op == etrl_pkg::OP_STORE) begin
                            r_wp_a[r_lg]   <= r_wp;
                            r_op_a[r_lg]   <= r_op;
                            r_fill_a[r_lg] <= r_fill;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_read_byte      = r_read_byte;
    assign o_read_valid     = r_read_valid;
    assign o_fill_level_out = r_fill_out;
    assign o_accepted       = r_accepted;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUSH) |->
            (r_fill <= FW'(LOG_DEPTH)) && ({1'b0, r_wp} < (PW+1)'(LOG_DEPTH)))
        else $error("ring state out of range while pushing");

    a_resp_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESP) && out_free |=> r_out_valid && (r_state == S_IDLE))
        else $error("response not presented");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state == S_EXEC))
        else $error("popped item not executed");

    a_raddr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RMEM) && r_rvalid |->
            ({1'b0, r_raddr[PW-1:0]} < (PW+1)'(LOG_DEPTH)))
        else $error("read address beyond log");
`endif

endmodule

[rtl/core/escaped_trace_ring_logger_core.sv]
// Store: one byte a cycle goes into the single write port.
// The back-end sequencer finishes one item before it pops the next; the front end
// takes beats while the back end works, until the queue and its register are full.
// Reset: synchronous, active low; clears every log's pointers, fill, type and clear flag.
// The trace memory is not cleared: only bytes below the fill level are ever returned.
module escaped_trace_ring_logger_core #(
    parameter int LOG_DEPTH  = etrl_pkg::LOG_DEPTH_DEF,
    parameter int NUM_LOGS   = etrl_pkg::NUM_LOGS_DEF,
    parameter int TIME_BYTES = etrl_pkg::TIME_BYTES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [etrl_pkg::CMD_W-1:0]        i_cmd,
    input  logic [etrl_pkg::SEL_W-1:0]        i_log_select,
    input  logic [etrl_pkg::BYTE_W-1:0]       i_frame_type,
    input  logic [etrl_pkg::BYTE_W-1:0]       i_data_byte,
    input  logic [etrl_pkg::TS_W-1:0]         i_timestamp,
    input  logic [etrl_pkg::OFF_W-1:0]        i_read_offset,
    // Result channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [etrl_pkg::BYTE_W-1:0]       o_read_byte,
    output logic                              o_read_valid,
    output logic [etrl_pkg::FILL_OUT_W-1:0]   o_fill_level_out,
    output logic                              o_accepted
);

    // Front to queue: classified beat
    etrl_pkg::t_slot push;
    // Queue to back: head of queue
    etrl_pkg::t_slot head;
    logic            queue_full;
    logic            pop;

    // Classify each beat: store, clear, read, unknown command, unknown log.
    // Hold it in one register until the queue has room.
    etrl_front #(
        .NUM_LOGS (NUM_LOGS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_cmd         (i_cmd),
        .i_log_select  (i_log_select),
        .i_frame_type  (i_frame_type),
        .i_data_byte   (i_data_byte),
        .i_timestamp   (i_timestamp),
        .i_read_offset (i_read_offset),
        .i_queue_full  (queue_full),
        .o_push        (push)
    );

    // Decouple the front end from the byte sequencer so each side stalls alone.
    etrl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (queue_full),
        .o_head  (head),
        .i_pop   (pop)
    );

    // Advance ring pointers, emit header, escape and data bytes one per cycle,
    // serve reads through the registered memory port, then present the result.
    etrl_back #(
        .LOG_DEPTH  (LOG_DEPTH),
        .NUM_LOGS   (NUM_LOGS),
        .TIME_BYTES (TIME_BYTES)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head           (head),
        .o_pop            (pop),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_read_byte      (o_read_byte),
        .o_read_valid     (o_read_valid),
        .o_fill_level_out (o_fill_level_out),
        .o_accepted       (o_accepted)
    );

endmodule

[bench/testbench.sv]
// Self-checking bench for the escaped trace ring logger core.
// Depends on etrl_pkg and escaped_trace_ring_logger_core; holds its own
// shadow of the logs to work out every result that the directed table does not give.
module testbench;

    localparam int CMD_W      = etrl_pkg::CMD_W;
    localparam int SEL_W      = etrl_pkg::SEL_W;
    localparam int BYTE_W     = etrl_pkg::BYTE_W;
    localparam int TS_W       = etrl_pkg::TS_W;
    localparam int OFF_W      = etrl_pkg::OFF_W;
    localparam int FILL_OUT_W = etrl_pkg::FILL_OUT_W;
    localparam logic [CMD_W-1:0]  CMD_STORE   = etrl_pkg::CMD_STORE;
    localparam logic [CMD_W-1:0]  CMD_CLEAR   = etrl_pkg::CMD_CLEAR;
    localparam logic [CMD_W-1:0]  CMD_READ    = etrl_pkg::CMD_READ;
    localparam logic [BYTE_W-1:0] ESCAPE_MARK = etrl_pkg::ESCAPE_MARK;

    localparam int DEPTH     = etrl_pkg::LOG_DEPTH_DEF;
    localparam int LOGS      = etrl_pkg::NUM_LOGS_DEF;
    localparam int TS_BYTES  = etrl_pkg::TIME_BYTES_DEF;
    localparam int LOG_SLOTS = 1 << SEL_W;
    localparam int NUM_DIRECTED = 25;
    localparam int IDLE_LIMIT   = 3000;
    localparam int HOLD_OFF     = 400;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [SEL_W-1:0]  sel;
        logic [BYTE_W-1:0] ftype;
        logic [BYTE_W-1:0] data;
        logic [TS_W-1:0]   ts;
        logic [OFF_W-1:0]  off;
    } t_beat;

    typedef struct packed {
        logic [BYTE_W-1:0]     rbyte;
        logic                  rvalid;
        logic [FILL_OUT_W-1:0] fill;
        logic                  acc;
    } t_result;

    typedef struct packed {
        t_beat   beat;
        logic    typed;
        t_result want;
    } t_row;

    logic                  i_clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  out_stall = 1'b0;
    logic [CMD_W-1:0]      cmd = '0;
    logic [SEL_W-1:0]      log_select = '0;
    logic [BYTE_W-1:0]     frame_type = '0;
    logic [BYTE_W-1:0]     data_byte = '0;
    logic [TS_W-1:0]       timestamp = '0;
    logic [OFF_W-1:0]      read_offset = '0;
    logic                  in_stall;
    logic                  out_valid;
    logic [BYTE_W-1:0]     read_byte;
    logic                  read_valid;
    logic [FILL_OUT_W-1:0] fill_level_out;
    logic                  accepted;

    // Shadow of the logs, updated as each beat is taken.
    logic [7:0]  ring_bytes [LOG_SLOTS][DEPTH];
    int unsigned head_pos   [LOG_SLOTS];
    int unsigned tail_pos   [LOG_SLOTS];
    int unsigned held_bytes [LOG_SLOTS];
    logic [7:0]  prev_type  [LOG_SLOTS];
    bit          wipe_due   [LOG_SLOTS];

    t_result awaited_results [$];
    t_row    directed_rows [NUM_DIRECTED];
    int      errors = 0;
    int      results_seen = 0;
    int      idle_cycles = 0;
    bit      burst = 1'b0;

    always #1 i_clk = ~i_clk;

    escaped_trace_ring_logger_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_cmd            (cmd),
        .i_log_select     (log_select),
        .i_frame_type     (frame_type),
        .i_data_byte      (data_byte),
        .i_timestamp      (timestamp),
        .i_read_offset    (read_offset),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_read_byte      (read_byte),
        .o_read_valid     (read_valid),
        .o_fill_level_out (fill_level_out),
        .o_accepted       (accepted)
    );

    // Push one byte into a log; once the log is full, drop its oldest byte.
    function automatic void append_byte(input int unsigned lg, input logic [7:0] v);
        ring_bytes[lg][tail_pos[lg]] = v;
        tail_pos[lg] = (tail_pos[lg] + 1) % DEPTH;
        if (held_bytes[lg] < DEPTH) begin
            held_bytes[lg]++;
        end else begin
            head_pos[lg] = (head_pos[lg] + 1) % DEPTH;
        end
    endfunction

    // Apply one beat to the shadow logs and return the result it must produce.
    function automatic t_result trace_outcome(input t_beat b);
        t_result     r;
        int unsigned lg;
        int unsigned pos;
        r = '0;
        lg = b.sel;
        // A log index past the built count leaves everything untouched and
        // answers with all fields low.
        if (lg >= LOGS) return r;
        case (b.cmd)
            CMD_STORE: begin
                // A pending clear takes effect only now, at the next store.
                if (wipe_due[lg]) begin
                    head_pos[lg] = 0;
                    tail_pos[lg] = 0;
                    held_bytes[lg] = 0;
                    prev_type[lg] = '0;
                    wipe_due[lg] = 1'b0;
                end
                if (b.ftype != prev_type[lg]) begin
                    append_byte(lg, ESCAPE_MARK);
                    append_byte(lg, b.ftype);
                    prev_type[lg] = b.ftype;
                    for (int i = 0; i < TS_BYTES && i < 8; i++)
                        append_byte(lg, b.ts[8*i +: 8]);
                end
                if (b.data == ESCAPE_MARK) append_byte(lg, ESCAPE_MARK);
                append_byte(lg, b.data);
            end
            CMD_CLEAR: wipe_due[lg] = 1'b1;
            CMD_READ: begin
                if (b.off < held_bytes[lg]) begin
                    pos = (head_pos[lg] + b.off) % DEPTH;
                    r.rbyte = ring_bytes[lg][pos];
                    r.rvalid = 1'b1;
                end
            end
            default: ;
        endcase
        r.fill = FILL_OUT_W'(held_bytes[lg]);
        r.acc = 1'b1;
        return r;
    endfunction

    // Gap length: mostly none or short, now and then long.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Build a random beat. While filling, aim nearly everything at log 3 with a
    // fresh frame type most of the time, so that the log wraps and overwrites.
    function automatic t_beat make_beat(input bit filling);
        t_beat       b;
        int          r;
        int          pick;
        int unsigned held;
        logic [7:0]  t;
        r = $urandom_range(0, 99);
        b.ts = {$urandom(), $urandom()};
        b.data = ($urandom_range(0, 99) < 15) ? ESCAPE_MARK : 8'($urandom());
        if (filling) begin
            b.sel = 2'd3;
            b.cmd = (r < 93) ? CMD_STORE : CMD_READ;
            if (r >= 98) begin
                // Stray traffic elsewhere; never a clear of the log being filled.
                b.sel = SEL_W'($urandom_range(0, 2));
                b.cmd = CMD_W'($urandom_range(0, 3));
            end
        end else begin
            b.sel = SEL_W'($urandom());
            b.cmd = (r < 40) ? CMD_STORE : (r < 78) ? CMD_READ :
                    (r < 93) ? CMD_CLEAR : CMD_UNUSED;
        end
        if ($urandom_range(0, 99) < (filling ? 90 : 45)) begin
            do t = 8'($urandom()); while (t == prev_type[b.sel]);
            b.ftype = t;
        end else begin
            b.ftype = prev_type[b.sel];
        end
        held = held_bytes[b.sel];
        pick = $urandom_range(0, 99);
        if (pick < 70 && held > 0) b.off = OFF_W'($urandom_range(0, held - 1));
        else if (pick < 80) b.off = '1;
        else if (pick < 88 && held < DEPTH) b.off = OFF_W'(held);
        else b.off = OFF_W'($urandom());
        return b;
    endfunction

    // Offer one beat from a falling edge, hold it until taken, note the result
    // it owes and return on the next falling edge.
    task automatic send_beat(input t_beat b, input logic typed, input t_result want);
        int      gap;
        t_result due;
        gap = burst ? 0 : idle_len();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cmd         <= b.cmd;
        log_select  <= b.sel;
        frame_type  <= b.ftype;
        data_byte   <= b.data;
        timestamp   <= b.ts;
        read_offset <= b.off;
        in_valid    <= 1'b1;
        do @(posedge i_clk); while (in_stall);
        due = trace_outcome(b);
        awaited_results.push_back(typed ? want : due);
        @(negedge i_clk);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    // Result side: compare every taken beat with the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (rst_n && out_valid && !out_stall) begin
            results_seen++;
            if (awaited_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0h %0b %0d %0b",
                         $time, read_byte, read_valid, fill_level_out, accepted);
                errors++;
            end else begin
                want = awaited_results.pop_front();
                check_field("read_byte", want.rbyte, read_byte);
                check_field("read_valid", want.rvalid, read_valid);
                check_field("fill_level_out", want.fill, fill_level_out);
                check_field("accepted", want.acc, accepted);
            end
        end
    end

    // Receiver: random stall runs, none during a burst, and one long hold-off
    // partway through that backs the block up into its input.
    initial begin : receiver
        int  stall_left;
        bit  held_off;
        stall_left = 0;
        held_off = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held_off && results_seen >= 150) begin
                held_off = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_OFF) @(negedge i_clk);
            end else if (burst) begin
                out_stall <= 1'b0;
            end else if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end else begin
                out_stall <= 1'b0;
                if ($urandom_range(0, 99) < 20) stall_left = idle_len() + 1;
            end
        end
    end

    // Count cycles in which no beat moves on either side.
    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    initial begin : watchdog
        while (idle_cycles < IDLE_LIMIT) @(posedge i_clk);
        $display("Verification failed");
        $finish;
    end

    initial begin : stimulus
        int n;
        // Directed table. Rows marked typed carry a result that can be read
        // straight off the behaviour; the rest take the shadow's answer.
        directed_rows = '{
            // empty log after reset
            '{'{CMD_READ,  2'd0, 8'h00, 8'h00, 64'h0, 12'd0},   1'b1, '{8'h00, 1'b0, 13'd0,  1'b1}},
            // type zero after reset: no header
            '{'{CMD_STORE, 2'd0, 8'h00, 8'h00, 64'h0, 12'd0},   1'b1, '{8'h00, 1'b0, 13'd1,  1'b1}},
            '{'{CMD_READ,  2'd0, 8'h00, 8'h00, 64'h0, 12'd0},   1'b1, '{8'h00, 1'b1, 13'd1,  1'b1}},
            // escape byte in the data is written twice
            '{'{CMD_STORE, 2'd0, 8'h00, 8'hAA, 64'h0, 12'd0},   1'b1, '{8'h00, 1'b0, 13'd3,  1'b1}},
            '{'{CMD_READ,  2'd0, 8'h00, 8'h00, 64'h0, 12'd2},   1'b1, '{8'hAA, 1'b1, 13'd3,  1'b1}},
            // type change with an all-ones stamp: ten header bytes then data
            '{'{CMD_STORE, 2'd0, 8'hFF, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 12'd0},
                                                                1'b1, '{8'h00, 1'b0, 13'd14, 1'b1}},
            '{'{CMD_READ,  2'd0, 8'h00, 8'h00, 64'h0, 12'd3},   1'b1, '{8'hAA, 1'b1, 13'd14, 1'b1}},
            '{'{CMD_READ,  2'd0, 8'h00, 8'h00, 64'h0, 12'd13},  1'b1, '{8'hFF, 1'b1, 13'd14, 1'b1}},
            // reads at and far beyond the fill level
            '{'{CMD_READ,  2'd0, 8'h00, 8'h00, 64'h0, 12'd14},  1'b1, '{8'h00, 1'b0, 13'd14, 1'b1}},
            '{'{CMD_READ,  2'd0, 8'h00, 8'h00, 64'h0, 12'hFFF}, 1'b1, '{8'h00, 1'b0, 13'd14, 1'b1}},
            // unknown command on log 0, every other field at its top value
            '{'{CMD_UNUSED, 2'd0, 8'hFF, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 12'hFFF},
                                                                1'b1, '{8'h00, 1'b0, 13'd14, 1'b1}},
            // clear is only marked; reads still see the old contents
            '{'{CMD_CLEAR, 2'd0, 8'h00, 8'h00, 64'h0, 12'd0},   1'b1, '{8'h00, 1'b0, 13'd14, 1'b1}},
            '{'{CMD_READ,  2'd0, 8'h00, 8'h00, 64'h0, 12'd4},   1'b1, '{8'hFF, 1'b1, 13'd14, 1'b1}},
            // next store applies the clear; type zero again needs no header
            '{'{CMD_STORE, 2'd0, 8'h00, 8'h55, 64'h0, 12'd0},   1'b1, '{8'h00, 1'b0, 13'd1,  1'b1}},
            '{'{CMD_READ,  2'd0, 8'h00, 8'h00, 64'h0, 12'd0},   1'b1, '{8'h55, 1'b1, 13'd1,  1'b1}},
            // stamp byte order, least significant first
            '{'{CMD_STORE, 2'd1, 8'h80, 8'h01, 64'h0123_4567_89AB_CDEF, 12'd0},
                                                                1'b1, '{8'h00, 1'b0, 13'd11, 1'b1}},
            '{'{CMD_READ,  2'd1, 8'h00, 8'h00, 64'h0, 12'd2},   1'b0, '0},
            '{'{CMD_READ,  2'd1, 8'h00, 8'h00, 64'h0, 12'd9},   1'b0, '0},
            // header plus escaped data
            '{'{CMD_STORE, 2'd2, 8'h01, 8'hAA, 64'h0, 12'd0},   1'b1, '{8'h00, 1'b0, 13'd12, 1'b1}},
            '{'{CMD_STORE, 2'd2, 8'h01, 8'hAA, 64'h0, 12'd0},   1'b0, '0},
            '{'{CMD_READ,  2'd3, 8'h00, 8'h00, 64'h0, 12'd0},   1'b1, '{8'h00, 1'b0, 13'd0,  1'b1}},
            '{'{CMD_CLEAR, 2'd1, 8'h00, 8'h00, 64'h0, 12'd0},   1'b1, '{8'h00, 1'b0, 13'd11, 1'b1}},
            '{'{CMD_STORE, 2'd1, 8'h7F, 8'h80, 64'h8000_0000_0000_0001, 12'd0}, 1'b0, '0},
            '{'{CMD_READ,  2'd1, 8'h00, 8'h00, 64'h0, 12'd1},   1'b0, '0},
            // back to type zero counts as a change
            '{'{CMD_STORE, 2'd2, 8'h00, 8'h00, 64'h0, 12'd0},   1'b0, '0}
        };

        // Hold reset at the start, then release it on a falling edge.
        repeat (10) @(negedge i_clk);
        rst_n <= 1'b1;

        foreach (directed_rows[k])
            send_beat(directed_rows[k].beat, directed_rows[k].typed, directed_rows[k].want);

        // Fill log 3 past its depth so the ring wraps and overwrites its oldest bytes.
        n = 0;
        while (n < 380 || (head_pos[3] < 300 && n < 1500)) begin
            send_beat(make_beat(1'b1), 1'b0, '0);
            n++;
        end

        // Mixed traffic on all logs, with one stretch free of any idling.
        for (int k = 0; k < 200; k++) begin
            burst = (k >= 20 && k < 80);
            send_beat(make_beat(1'b0), 1'b0, '0);
        end
        burst = 1'b0;
        in_valid <= 1'b0;

        // Drain, then allow the longest store latency and some margin.
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (errors == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end

endmodule
